// ===== design/sst_pkg.sv =====
package sst_pkg;

	// Default table depth.
	localparam int SLOTS_DEF = 8;

	// Fixed field widths of the word on each channel.
	localparam int FUNC_W    = 2;
	localparam int SLOT_IN_W = 3;
	localparam int SUM_W     = 32;
	localparam int OUT_W     = 4;

	// Operation codes carried in the func field.
	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC   = 2'd0,
		FN_RELEASE = 2'd1,
		FN_SETSUM  = 2'd2,
		FN_RANK    = 2'd3
	} func_t;

	// Controls from the sequencer to the rank accumulator.
	typedef struct packed {
		logic load_mine;  // read data holds the queried slot's own sum
		logic cmp_en;     // read data holds the sum of the slot under scan
		logic counted;    // the slot under scan is active and not the queried one
	} rank_ctl_t;

endpackage

// ===== design/sst_sum_mem.sv =====
module sst_sum_mem #(
	parameter int SLOTS = sst_pkg::SLOTS_DEF,
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [sst_pkg::SUM_W-1:0]  wdata,
	input  logic                       re,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [sst_pkg::SUM_W-1:0]  rdata
);
	import sst_pkg::*;

	logic [SUM_W-1:0] mem [SLOTS];
	logic [SUM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sst_rank_acc.sv =====
module sst_rank_acc #(
	parameter int SLOTS = sst_pkg::SLOTS_DEF,
	localparam int CNT_W = $clog2(SLOTS + 1)
) (
	input  logic                       clk,
	input  sst_pkg::rank_ctl_t         ctl,
	input  logic [sst_pkg::SUM_W-1:0]  rdata,
	output logic [CNT_W-1:0]           rank
);
	import sst_pkg::*;

	logic [SUM_W-1:0] mine_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W-1:0] s_q;

	// Sums are two's complement, so a signed compare gives the ranking order.
	always_ff @(posedge clk) begin
		if (ctl.load_mine) begin
			mine_q <= rdata;
			r_q    <= CNT_W'(1);
			s_q    <= CNT_W'(1);
		end else if (ctl.cmp_en && ctl.counted) begin
			if ($signed(rdata) > $signed(mine_q)) begin
				r_q <= r_q + CNT_W'(1);
			end else if (rdata == mine_q) begin
				s_q <= s_q + CNT_W'(1);
			end
		end
	end

	// Ties share the middle place, truncated: r + floor((s - 1) / 2).
	assign rank = CNT_W'(r_q + ((s_q - CNT_W'(1)) >> 1));

endmodule

// ===== design/slot_score_table_with_ranking_top.sv =====
// Allocate, release, set-sum and a rank query on a free slot pass through EXEC and DONE
// before their result enters the output register; a rank query on an active slot also
// passes through LOAD and a SCAN that reads every slot in turn from the sum memory.
// A new word is taken only in IDLE, so a word is not taken before the last one has
// handed over its result; the single read port of the sum memory makes the scan serial.
// Reset (arst_n low, asynchronous) frees every slot, clears the active count and the sequencer
// and drops out_valid; the sum memory needs no clearing because allocate writes a zero sum.
module slot_score_table_with_ranking_top #(
	parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sst_pkg::FUNC_W-1:0]     func,
	input  logic [sst_pkg::SLOT_IN_W-1:0]  slot,
	input  logic signed [sst_pkg::SUM_W-1:0] sum_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sst_pkg::OUT_W-1:0]      slot_out,
	output logic [sst_pkg::OUT_W-1:0]      rank_out,
	output logic [sst_pkg::OUT_W-1:0]      active_count,
	output logic                           slot_active
);
	import sst_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

	// The sequencer. EXEC carries out the operation; a rank query on an active slot
	// then loads its own sum (LOAD) and sweeps every slot once (SCAN). DONE hands
	// the result to the output register as soon as that register is free.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t            state_q;
	func_t             func_q;
	logic [SLOT_IN_W-1:0] slot_q;
	logic [SUM_W-1:0]  value_q;
	logic [SLOTS-1:0]  flags_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] k_q;
	logic              rank_pending_q;
	logic [OUT_W-1:0]  res_slot_q;
	logic              res_act_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  slot_out_q;
	logic [OUT_W-1:0]  rank_out_q;
	logic [OUT_W-1:0]  active_count_q;
	logic              slot_active_q;

	logic              fire;
	logic              out_free;
	logic              in_range;
	logic [SLOT_W-1:0] sl_idx;
	logic              slot_flag;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [SUM_W-1:0]  mem_wdata;
	logic              mem_re;
	logic [SLOT_W-1:0] mem_raddr;
	logic [SUM_W-1:0]  mem_rdata;
	rank_ctl_t         rctl;
	logic [CNT_W-1:0]  rank_val;

	// A new word is taken only while the sequencer is idle. The output register
	// parts the two sides, so the next word may enter while a result still waits.
	assign in_stall = (state_q != ST_IDLE);
	assign fire     = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// A slot number beyond the table leaves all state alone.
	assign in_range  = (int'(slot_q) < SLOTS);
	assign sl_idx    = SLOT_W'(slot_q);
	assign slot_flag = in_range && flags_q[sl_idx];

	// Lowest free slot for allocate.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!flags_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	// Sum memory accesses. All writes happen in EXEC and a rank query writes nothing, so
	// its reads, from EXEC through SCAN, never meet a write within the same word.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sl_idx;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = sl_idx;
		rctl      = '0;
		unique case (state_q)
			ST_EXEC: begin
				unique case (func_q)
					FN_ALLOC: begin
						mem_we    = free_found;
						mem_waddr = free_idx;
					end
					FN_RELEASE: begin
						mem_we = in_range;
					end
					FN_SETSUM: begin
						mem_we    = in_range;
						mem_wdata = value_q;
					end
					FN_RANK: begin
						mem_re = slot_flag;
					end
					default: begin
					end
				endcase
			end
			ST_LOAD: begin
				rctl.load_mine = 1'b1;
				mem_re         = 1'b1;
				mem_raddr      = '0;
			end
			ST_SCAN: begin
				rctl.cmp_en  = 1'b1;
				rctl.counted = flags_q[k_q] && (k_q != sl_idx);
				if (k_q != LAST_IDX) begin
					mem_re    = 1'b1;
					mem_raddr = k_q + SLOT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	sst_sum_mem #(
		.SLOTS(SLOTS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sst_rank_acc #(
		.SLOTS(SLOTS)
	) u_rank (
		.clk  (clk),
		.ctl  (rctl),
		.rdata(mem_rdata),
		.rank (rank_val)
	);

	// Sequencer, active flags, active count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			flags_q        <= '0;
			count_q        <= '0;
			k_q            <= '0;
			rank_pending_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rank_pending_q <= 1'b0;
					state_q        <= ST_DONE;
					unique case (func_q)
						FN_ALLOC: begin
							if (free_found) begin
								flags_q[free_idx] <= 1'b1;
								count_q           <= count_q + CNT_W'(1);
							end
						end
						FN_RELEASE: begin
							if (slot_flag) begin
								flags_q[sl_idx] <= 1'b0;
								count_q         <= count_q - CNT_W'(1);
							end
						end
						FN_RANK: begin
							if (slot_flag) begin
								rank_pending_q <= 1'b1;
								state_q        <= ST_LOAD;
							end
						end
						default: begin
						end
					endcase
				end
				ST_LOAD: begin
					k_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (k_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q + SLOT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured word, per-word result and the output register.
	always_ff @(posedge clk) begin
		if (fire) begin
			func_q  <= func_t'(func);
			slot_q  <= slot;
			value_q <= sum_value;
		end
		if (state_q == ST_EXEC) begin
			if (func_q == FN_ALLOC) begin
				res_slot_q <= free_found ? OUT_W'(free_idx) : OUT_W'(SLOTS);
				res_act_q  <= free_found;
			end else begin
				res_slot_q <= OUT_W'(slot_q);
				res_act_q  <= (func_q == FN_RELEASE) ? 1'b0 : slot_flag;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			slot_out_q     <= res_slot_q;
			rank_out_q     <= rank_pending_q ? OUT_W'(rank_val) : OUT_W'(1);
			active_count_q <= OUT_W'(count_q);
			slot_active_q  <= res_act_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign slot_out     = slot_out_q;
	assign rank_out     = rank_out_q;
	assign active_count = active_count_q;
	assign slot_active  = slot_active_q;

	// The running count always agrees with the flags it summarizes.
	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(flags_q)))
		else $error("active count differs from the number of set active flags");

	// The sweep never addresses a slot beyond the table.
	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (int'(k_q) < SLOTS))
		else $error("rank sweep index beyond the table");

	// No sum is written while a query is reading the table.
	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_SCAN) |-> !mem_we)
		else $error("sum memory written during a rank sweep");

	// A query result is delivered only after the sweep has covered the last slot.
	a_sweep_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && $past(state_q) == ST_SCAN) |-> ($past(k_q) == LAST_IDX))
		else $error("rank sweep ended early");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sst_pkg::*;

	localparam int SLOTS = SLOTS_DEF;

	// The run is declared hung once the count of cycles in a row in which no word moves
	// on either channel reaches this limit. The slowest legal gap, a rank query on an
	// active slot behind a long random stall, stays far below this limit.
	localparam int QUIET_LIMIT = 4000;

	// One expected result word, laid out like the output ports.
	typedef struct {
		logic [OUT_W-1:0] slot_idx;
		logic [OUT_W-1:0] rank;
		logic [OUT_W-1:0] busy_total;
		logic             busy;
	} table_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	func_t                     func;
	logic [SLOT_IN_W-1:0]      slot;
	logic signed [SUM_W-1:0]   sum_value;
	logic                      out_valid;
	logic                      out_stall;
	logic [OUT_W-1:0]          slot_out;
	logic [OUT_W-1:0]          rank_out;
	logic [OUT_W-1:0]          active_count;
	logic                      slot_active;

	// Shadow copy of the slot table, updated in acceptance order.
	logic                      slot_busy [SLOTS];
	logic signed [SUM_W-1:0]   slot_score [SLOTS];

	// Results that accepted words still owe, oldest first.
	table_result_t             pending_results [$];

	int                        mismatches = 0;
	int                        send_idle_pct = 0;
	int                        recv_stall_pct = 0;

	slot_score_table_with_ranking_top #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.slot         (slot),
		.sum_value    (sum_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot_out     (slot_out),
		.rank_out     (rank_out),
		.active_count (active_count),
		.slot_active  (slot_active)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Counts the active entries of the shadow table.
	function automatic int busy_slots();
		int n;
		n = 0;
		for (int k = 0; k < SLOTS; k++)
			if (slot_busy[k])
				n++;
		return n;
	endfunction

	// Applies one accepted word to the shadow table and returns the result it must
	// produce. A rank is one plus the active slots that score higher, plus half of the
	// other active slots that tie with it, rounded down. A free slot always ranks first.
	function automatic table_result_t table_update(input func_t op,
			input logic [SLOT_IN_W-1:0] idx, input logic signed [SUM_W-1:0] value);
		table_result_t res;
		int            above;
		int            ties;
		res.slot_idx = OUT_W'(idx);
		res.rank     = OUT_W'(1);
		res.busy     = 1'b0;
		case (op)
			FN_ALLOC: begin
				// Lowest free slot wins; a full table reports SLOTS and changes nothing.
				res.slot_idx = OUT_W'(SLOTS);
				for (int k = 0; k < SLOTS; k++) begin
					if (!slot_busy[k]) begin
						slot_busy[k]  = 1'b1;
						slot_score[k] = '0;
						res.slot_idx  = OUT_W'(k);
						res.busy      = 1'b1;
						break;
					end
				end
			end
			FN_RELEASE: begin
				slot_busy[idx]  = 1'b0;
				slot_score[idx] = '0;
			end
			FN_SETSUM: begin
				slot_score[idx] = value;
				res.busy = slot_busy[idx];
			end
			default: begin
				if (slot_busy[idx]) begin
					above = 0;
					ties  = 0;
					for (int k = 0; k < SLOTS; k++) begin
						if (k != idx && slot_busy[k]) begin
							if (slot_score[k] > slot_score[idx])
								above++;
							else if (slot_score[k] == slot_score[idx])
								ties++;
						end
					end
					res.rank = OUT_W'(1 + above + ties / 2);
				end
				res.busy = slot_busy[idx];
			end
		endcase
		res.busy_total = OUT_W'(busy_slots());
		return res;
	endfunction

	// Prints one line for a mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("error at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Result side: the receiver stalls at random at the current rate, and every word it
	// takes is compared with the oldest result still owed. All values are read as they
	// stood just before the edge, since every drive after time zero but the clock is nonblocking.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word arrived with nothing outstanding");
			end else begin
				want = pending_results.pop_front();
				compare_field("slot_out", slot_out, want.slot_idx);
				compare_field("rank_out", rank_out, want.rank);
				compare_field("active_count", active_count, want.busy_total);
				compare_field("slot_active", slot_active, want.busy);
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Hang detection: the run ends in failure once the count of cycles in a row in which
	// neither channel moves a word reaches QUIET_LIMIT.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// Sends one word. It must be called at a rising edge and returns at the edge that
	// accepted the word, with valid still high so that back-to-back words keep it up.
	// Before the word, the sender may sit idle for a random number of cycles.
	task automatic send_word(input func_t op, input logic [SLOT_IN_W-1:0] idx,
			input logic signed [SUM_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= op;
		slot      <= idx;
		sum_value <= value;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pending_results.push_back(table_update(op, idx, value));
	endtask

	// Holds the sender off until every owed result has come back. Valid is only
	// lowered when time is really going to pass, so it never drops and rises in the
	// same step.
	task automatic wait_drained();
		if (pending_results.size() != 0) begin
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	// Sums are drawn mostly from a narrow band so that ties and close orderings are
	// common, with the signed extremes and fully random patterns mixed in.
	function automatic logic signed [SUM_W-1:0] pick_sum();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return SUM_W'($urandom_range(4)) - SUM_W'(2);
			5: return 32'sh8000_0000;
			6: return 32'sh7FFF_FFFF;
			7: return $urandom_range(1) ? 32'sh8000_0001 : 32'sh7FFF_FFFE;
			default: return $urandom;
		endcase
	endfunction

	// Random word shaped to keep the table busy: allocation is favored while the table
	// is sparse and still tried when it is full, and most addressed words go to an
	// active slot so that set-sum and rank queries do real work.
	task automatic send_random_word();
		int                   busy_n;
		int                   pick;
		int                   alloc_pct;
		int                   live [$];
		func_t                op;
		logic [SLOT_IN_W-1:0] idx;
		busy_n    = busy_slots();
		alloc_pct = 10 + 5 * (SLOTS - busy_n);
		pick      = $urandom_range(99);
		if (pick < alloc_pct)
			op = FN_ALLOC;
		else if (pick < alloc_pct + 12)
			op = FN_RELEASE;
		else if (pick < alloc_pct + 12 + (88 - alloc_pct) / 2)
			op = FN_SETSUM;
		else
			op = FN_RANK;
		for (int k = 0; k < SLOTS; k++)
			if (slot_busy[k])
				live.push_back(k);
		if (live.size() != 0 && $urandom_range(99) < 80)
			idx = SLOT_IN_W'(live[$urandom_range(live.size() - 1)]);
		else
			idx = SLOT_IN_W'($urandom);
		send_word(op, idx, pick_sum());
	endtask

	task automatic run_random_phase(input int words, input int s_pct, input int r_pct);
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		repeat (words)
			send_random_word();
		wait_drained();
	endtask

	// Directed cases: queries and releases on free slots, a set-sum on a free slot that
	// allocate must later clear, filling the table, allocate on a full table, signed
	// extremes with ties, and reuse of a released slot.
	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_word(FN_RANK, 3'd0, 32'sh1234_5678);
		send_word(FN_RELEASE, 3'd5, 32'sh0);
		send_word(FN_SETSUM, 3'd3, 32'sh7FFF_FFFF);
		send_word(FN_RANK, 3'd3, 32'sh0);
		for (int k = 0; k < SLOTS; k++)
			send_word(FN_ALLOC, 3'd7, $urandom);
		send_word(FN_ALLOC, 3'd0, 32'sh0);
		send_word(FN_SETSUM, 3'd0, 32'sh8000_0000);
		send_word(FN_SETSUM, 3'd1, 32'sh7FFF_FFFF);
		send_word(FN_SETSUM, 3'd2, 32'sh7FFF_FFFF);
		send_word(FN_SETSUM, 3'd3, 32'sh7FFF_FFFF);
		send_word(FN_RANK, 3'd0, 32'sh0);
		send_word(FN_RANK, 3'd1, 32'sh0);
		send_word(FN_RANK, 3'd4, 32'sh0);
		send_word(FN_RELEASE, 3'd2, 32'shFFFF_FFFF);
		send_word(FN_RANK, 3'd1, 32'sh0);
		send_word(FN_ALLOC, 3'd0, 32'sh0);
		send_word(FN_SETSUM, 3'd7, 32'shFFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_streaming();
		run_random_phase(400, 0, 0);
	endtask

	task automatic test_sender_gaps();
		run_random_phase(400, 75, 0);
	endtask

	task automatic test_receiver_backpressure();
		run_random_phase(400, 0, 75);
	endtask

	task automatic test_both_sparse();
		run_random_phase(350, 6, 6);
	endtask

	// Short bursts, each followed by a pause until the table has answered everything,
	// so the block is seen going fully idle between bursts under moderate stalling.
	task automatic test_drain_pause();
		repeat (4)
			run_random_phase(15, 30, 50);
	endtask

	initial begin
		// Every input is known from time zero, and reset is held low before the first word is sent.
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FN_ALLOC;
		slot      = '0;
		sum_value = '0;
		out_stall = 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			slot_busy[k]  = 1'b0;
			slot_score[k] = '0;
		end
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_streaming();
		test_sender_gaps();
		test_receiver_backpressure();
		test_both_sparse();
		test_drain_pause();

		// Let any stray late word show up before the verdict.
		in_valid       <= 1'b0;
		recv_stall_pct = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8)
			@(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
